// File: sv/ambient_light_lux_convert_top_macros.svh
// Assertion helpers shared by the lux converter modules.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef AMBIENT_LIGHT_LUX_CONVERT_TOP_MACROS_SVH
`define AMBIENT_LIGHT_LUX_CONVERT_TOP_MACROS_SVH

// Same-cycle implication
`define ALC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("alc assertion failed");

// Next-cycle implication
`define ALC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("alc assertion failed");

`endif

// File: sv/alc_pkg.sv
package alc_pkg;

  localparam int POW_TABLE_DEPTH = 64;
  localparam int LUX_FRAC_BITS   = 10;
  localparam int COEF_Q          = 24;
  localparam int CNT_W           = 16;
  localparam int LUX_W           = 21;
  localparam int REGION_W        = 3;

  // quotient width of the table index, numerator width of the index division
  localparam int KW    = $clog2(POW_TABLE_DEPTH + 1);
  localparam int NUM_W = CNT_W + $clog2(4 * POW_TABLE_DEPTH) + 1;
  localparam int DIV_W = NUM_W + KW + 1;

  localparam int PROD_W   = 37;
  localparam int ROUND_SH = COEF_Q - LUX_FRAC_BITS;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // region codes
  localparam logic [REGION_W-1:0] REGION_POW  = 3'd0;
  localparam logic [REGION_W-1:0] REGION_MIX1 = 3'd1;
  localparam logic [REGION_W-1:0] REGION_MIX2 = 3'd2;
  localparam logic [REGION_W-1:0] REGION_MIX3 = 3'd3;
  localparam logic [REGION_W-1:0] REGION_ZERO = 3'd4;

  // Q0.24 coefficients
  localparam logic [20:0] K_R0_B = 21'd510027;
  localparam logic [20:0] K_R0_P = 21'd1040187;
  localparam logic [20:0] K_R1_B = 21'd375810;
  localparam logic [20:0] K_R1_I = 21'd520094;
  localparam logic [20:0] K_R2_B = 21'd214748;
  localparam logic [20:0] K_R2_I = 21'd256691;
  localparam logic [20:0] K_R3_B = 21'd24495;
  localparam logic [20:0] K_R3_I = 21'd18790;

  localparam logic [LUX_W-1:0] LUX_MAX = {LUX_W{1'b1}};

  typedef struct packed {
    logic [CNT_W-1:0]    bb;
    logic [CNT_W-1:0]    ir;
    logic [REGION_W-1:0] region;
    logic [KW-1:0]       k;
  } alc_item_t;

  typedef logic [COEF_Q-1:0] pow_tab_t [0:POW_TABLE_DEPTH];

  function automatic logic [63:0] fifth_q24(input logic [63:0] y);
    logic [63:0] y2;
    logic [63:0] y4;
    y2 = (y * y) >> COEF_Q;
    y4 = (y2 * y2) >> COEF_Q;
    return (y4 * y) >> COEF_Q;
  endfunction

  // ratio^1.4 over ratio = k/(2*depth), built at elaboration
  function automatic pow_tab_t build_pow_tab();
    pow_tab_t    tab;
    logic [63:0] xq;
    logic [63:0] x2;
    logic [63:0] y;
    logic [63:0] cand;
    for (int k = 0; k <= POW_TABLE_DEPTH; k++) begin
      xq = (64'(k) << COEF_Q) / (2 * POW_TABLE_DEPTH);
      x2 = (xq * xq) >> COEF_Q;
      y  = '0;
      for (int bt = COEF_Q - 1; bt >= 0; bt--) begin
        cand = y | (64'd1 << bt);
        if (fifth_q24(cand) <= x2) begin
          y = cand;
        end
      end
      tab[k] = COEF_Q'((xq * y) >> COEF_Q);
    end
    return tab;
  endfunction

  localparam pow_tab_t POW_TAB = build_pow_tab();

endpackage

// File: sv/alc_front.sv
`include "ambient_light_lux_convert_top_macros.svh"

module alc_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [alc_pkg::CNT_W-1:0] bb_in,
  input  logic [alc_pkg::CNT_W-1:0] ir_in,
  input  logic                   q_full,
  output logic                   q_push,
  output alc_pkg::alc_item_t     q_item
);

  localparam int KW = alc_pkg::KW;

  logic [KW:0]                      v_r;
  logic [alc_pkg::CNT_W-1:0]        bb_r  [0:KW];
  logic [alc_pkg::CNT_W-1:0]        ir_r  [0:KW];
  logic [alc_pkg::REGION_W-1:0]     rg_r  [0:KW];
  logic [alc_pkg::NUM_W-1:0]        rem_r [0:KW];
  logic [KW-1:0]                    q_r   [0:KW];
  logic [alc_pkg::NUM_W-1:0]        rem_nxt [1:KW];
  logic [KW-1:0]                    q_nxt   [1:KW];
  logic [alc_pkg::REGION_W-1:0]     rg_in;
  logic [alc_pkg::NUM_W-1:0]        num_in;
  logic                             fe;
  logic                             accept;

  // whole front advances unless the last stage is blocked by a full queue
  assign fe       = !v_r[KW] || !q_full;
  assign in_ready = fe;
  assign accept   = in_valid && fe;
  assign q_push   = v_r[KW] && !q_full;
  assign q_item   = '{bb: bb_r[KW], ir: ir_r[KW], region: rg_r[KW], k: q_r[KW]};

  // region classification by exact cross-multiplication
  always_comb begin
    logic [23:0] b24;
    logic [23:0] i24;
    b24 = 24'(bb_in);
    i24 = 24'(ir_in);
    if (bb_in == '0 || 24'd10 * i24 > 24'd13 * b24) begin
      rg_in = alc_pkg::REGION_ZERO;
    end else if (ir_in != '0 && 24'd2 * i24 <= b24) begin
      rg_in = alc_pkg::REGION_POW;
    end else if (24'd100 * i24 <= 24'd61 * b24) begin
      rg_in = alc_pkg::REGION_MIX1;
    end else if (24'd5 * i24 <= 24'd4 * b24) begin
      rg_in = alc_pkg::REGION_MIX2;
    end else begin
      rg_in = alc_pkg::REGION_MIX3;
    end
    num_in = alc_pkg::NUM_W'(ir_in) * alc_pkg::NUM_W'(4 * alc_pkg::POW_TABLE_DEPTH)
           + alc_pkg::NUM_W'(bb_in);
  end

  // one quotient bit per stage: (4*D*ir + b) / (2*b)
  always_comb begin
    logic [alc_pkg::DIV_W-1:0] dv;
    logic [alc_pkg::DIV_W-1:0] rx;
    for (int s = 1; s <= KW; s++) begin
      dv = alc_pkg::DIV_W'({bb_r[s-1], 1'b0}) << (KW - s);
      rx = alc_pkg::DIV_W'(rem_r[s-1]);
      q_nxt[s] = q_r[s-1];
      if (rx >= dv) begin
        rem_nxt[s] = alc_pkg::NUM_W'(rx - dv);
        q_nxt[s][KW-s] = 1'b1;
      end else begin
        rem_nxt[s] = rem_r[s-1];
      end
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (fe) begin
      v_r <= {v_r[KW-1:0], accept};
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (fe) begin
      bb_r[0]  <= bb_in;
      ir_r[0]  <= ir_in;
      rg_r[0]  <= rg_in;
      rem_r[0] <= num_in;
      q_r[0]   <= '0;
      for (int s = 1; s <= KW; s++) begin
        bb_r[s]  <= bb_r[s-1];
        ir_r[s]  <= ir_r[s-1];
        rg_r[s]  <= rg_r[s-1];
        rem_r[s] <= rem_nxt[s];
        q_r[s]   <= q_nxt[s];
      end
    end
  end

  `ALC_ASSERT_NEXT(a_front_hold, v_r[KW] && q_full, v_r[KW])
  `ALC_ASSERT_SAME(a_front_kmax, v_r[KW] && rg_r[KW] == alc_pkg::REGION_POW,
                   32'(q_r[KW]) <= alc_pkg::POW_TABLE_DEPTH)

endmodule

// File: sv/alc_queue.sv
`include "ambient_light_lux_convert_top_macros.svh"

module alc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  alc_pkg::alc_item_t push_item,
  input  logic               pop,
  output alc_pkg::alc_item_t pop_item,
  output logic               full,
  output logic               empty
);

  alc_pkg::alc_item_t                mem_r [0:alc_pkg::QUEUE_DEPTH-1];
  logic [alc_pkg::QPTR_W-1:0]        wr_r;
  logic [alc_pkg::QPTR_W-1:0]        rd_r;
  logic [alc_pkg::QCNT_W-1:0]        cnt_r;

  function automatic logic [alc_pkg::QCNT_W-1:0] QCNT_INC(input logic x);
    return {{(alc_pkg::QCNT_W-1){1'b0}}, x};
  endfunction

  assign full     = cnt_r == alc_pkg::QCNT_W'(alc_pkg::QUEUE_DEPTH);
  assign empty    = cnt_r == '0;
  assign pop_item = mem_r[rd_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + QCNT_INC(push) - QCNT_INC(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_item;
  end

  `ALC_ASSERT_SAME(a_queue_flow, (push && full) || (pop && empty), 1'b0)

endmodule

// File: sv/alc_back.sv
`include "ambient_light_lux_convert_top_macros.svh"

module alc_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  alc_pkg::alc_item_t           q_item,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [alc_pkg::LUX_W-1:0]    lux,
  output logic [alc_pkg::REGION_W-1:0] region
);

  localparam int PW = alc_pkg::PROD_W;

  logic                          be;
  logic                          v1_r, v2_r, v3_r, vo_r;
  logic [alc_pkg::CNT_W-1:0]     bb1_r, ir1_r;
  logic [alc_pkg::COEF_Q-1:0]    t1_r;
  logic [alc_pkg::REGION_W-1:0]  rg1_r, rg2_r, rg3_r, rgo_r;
  logic [39:0]                   pbt2_r;
  logic [PW-1:0]                 pos2_r, negl2_r, pos3_r, neg3_r;
  logic [alc_pkg::LUX_W-1:0]     luxo_r;
  logic [20:0]                   kb, ki;
  logic [60:0]                   p0_full;
  logic [PW-1:0]                 diff;
  logic [PW:0]                   rnd;
  logic [PW-alc_pkg::ROUND_SH:0] shd;
  logic [alc_pkg::LUX_W-1:0]     lux_nxt;

  assign be        = !vo_r || out_ready;
  assign q_pop     = be && !q_empty;
  assign out_valid = vo_r;
  assign lux       = luxo_r;
  assign region    = rgo_r;

  // coefficients per region
  always_comb begin
    case (rg1_r)
      alc_pkg::REGION_POW:  begin kb = alc_pkg::K_R0_B; ki = '0; end
      alc_pkg::REGION_MIX1: begin kb = alc_pkg::K_R1_B; ki = alc_pkg::K_R1_I; end
      alc_pkg::REGION_MIX2: begin kb = alc_pkg::K_R2_B; ki = alc_pkg::K_R2_I; end
      alc_pkg::REGION_MIX3: begin kb = alc_pkg::K_R3_B; ki = alc_pkg::K_R3_I; end
      default:              begin kb = '0; ki = '0; end
    endcase
  end

  // second product of the power term, and rounding of the difference
  always_comb begin
    p0_full = 61'(pbt2_r) * 61'(alc_pkg::K_R0_P);
    diff    = pos3_r - neg3_r;
    rnd     = (PW+1)'(diff) + ((PW+1)'(1) << (alc_pkg::ROUND_SH - 1));
    shd     = (PW-alc_pkg::ROUND_SH+1)'(rnd >> alc_pkg::ROUND_SH);
    if (pos3_r <= neg3_r) begin
      lux_nxt = '0;
    end else if (shd > (PW-alc_pkg::ROUND_SH+1)'(alc_pkg::LUX_MAX)) begin
      lux_nxt = alc_pkg::LUX_MAX;
    end else begin
      lux_nxt = alc_pkg::LUX_W'(shd);
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (be) begin
      v1_r <= q_pop;
      v2_r <= v1_r;
      v3_r <= v2_r;
      vo_r <= v3_r;
    end
  end

  // datapath: table read, products, power product, round and clamp
  always_ff @(posedge clk) begin
    if (be) begin
      bb1_r   <= q_item.bb;
      ir1_r   <= q_item.ir;
      rg1_r   <= q_item.region;
      t1_r    <= alc_pkg::POW_TAB[q_item.k];
      pbt2_r  <= 40'(bb1_r) * 40'(t1_r);
      pos2_r  <= PW'(bb1_r) * PW'(kb);
      negl2_r <= PW'(ir1_r) * PW'(ki);
      rg2_r   <= rg1_r;
      pos3_r  <= pos2_r;
      neg3_r  <= (rg2_r == alc_pkg::REGION_POW) ? p0_full[60:alc_pkg::COEF_Q] : negl2_r;
      rg3_r   <= rg2_r;
      luxo_r  <= lux_nxt;
      rgo_r   <= rg3_r;
    end
  end

  `ALC_ASSERT_SAME(a_back_zero, vo_r && rgo_r == alc_pkg::REGION_ZERO, luxo_r == '0)

endmodule

// File: sv/ambient_light_lux_convert_top.sv
// Two-channel ambient light to lux converter.
// Pipeline: 8-stage index divider, 4-entry queue and 4-stage
// multiply/round back end.
// Throughput: one transaction per cycle while out_tready is held high.
// Reset: synchronous active-low rst_n clears all valids and queue pointers.
module ambient_light_lux_convert_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] broadband_count, [31:16] infrared_count
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] lux_scaled, [23:21] zero
  output logic [2:0]  out_tuser   // [2:0] ratio_region
);

  alc_pkg::alc_item_t              push_item, pop_item;
  logic                            push, pop, full, empty;
  logic [alc_pkg::LUX_W-1:0]       lux;

  alc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .bb_in    (in_tdata[15:0]),
    .ir_in    (in_tdata[31:16]),
    .q_full   (full),
    .q_push   (push),
    .q_item   (push_item)
  );

  alc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .full      (full),
    .empty     (empty)
  );

  alc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (empty),
    .q_item    (pop_item),
    .q_pop     (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .lux       (lux),
    .region    (out_tuser)
  );

  assign out_tdata = {3'b000, lux};

endmodule

// File: verif/ambient_light_lux_convert_top_tb.sv
module ambient_light_lux_convert_top_tb;
  import alc_pkg::*;

  typedef struct {
    logic [CNT_W-1:0] bb;
    logic [CNT_W-1:0] ir;
    bit               drain_first;  // hold off until all results are back
  } reading_t;

  typedef struct {
    logic [LUX_W-1:0]    lux;
    logic [REGION_W-1:0] region;
  } lux_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [15:0] broadband_count, [31:16] infrared_count
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // [20:0] lux_scaled, [23:21] zero
  logic [2:0]  out_tuser;       // [2:0] ratio_region

  reading_t    pending_readings[$];
  lux_result_t expected_lux[$];
  logic [63:0] pow14_tab[0:POW_TABLE_DEPTH];
  int          readings_sent = 0;
  int          errors = 0;
  bit          stim_ready = 1'b0;

  ambient_light_lux_convert_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // Clock and reset
  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Q24 ratio^1.4: y^5 <= x^2 by bisection, then x*y
  function automatic logic [63:0] quint_q24(logic [63:0] v);
    logic [63:0] sq;
    logic [63:0] qd;
    sq = (v * v) >> COEF_Q;
    qd = (sq * sq) >> COEF_Q;
    return (qd * v) >> COEF_Q;
  endfunction

  function automatic void fill_pow14();
    logic [63:0] xq;
    logic [63:0] xsq;
    logic [63:0] root;
    logic [63:0] trial;
    for (int k = 0; k <= POW_TABLE_DEPTH; k++) begin
      xq   = (64'(k) << COEF_Q) / (2 * POW_TABLE_DEPTH);
      xsq  = (xq * xq) >> COEF_Q;
      root = '0;
      for (int b = COEF_Q - 1; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (quint_q24(trial) <= xsq) root = trial;
      end
      pow14_tab[k] = (xq * root) >> COEF_Q;
    end
  endfunction

  // Expected lux and region for one reading
  function automatic lux_result_t compute_lux(logic [CNT_W-1:0] bb_c, logic [CNT_W-1:0] ir_c);
    lux_result_t r;
    logic [63:0] b;
    logic [63:0] i;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] idx;
    logic [63:0] lx;
    b = 64'(bb_c);
    i = 64'(ir_c);
    if (b == 0 || 10 * i > 13 * b) begin
      r.lux = '0;
      r.region = REGION_ZERO;
      return r;
    end
    if (i != 0 && 2 * i <= b) begin
      idx = (4 * POW_TABLE_DEPTH * i + b) / (2 * b);
      if (idx > POW_TABLE_DEPTH) idx = POW_TABLE_DEPTH;
      r.region = REGION_POW;
      pos = b * 64'(K_R0_B);
      neg = (b * pow14_tab[idx] * 64'(K_R0_P)) >> COEF_Q;
    end else if (100 * i <= 61 * b) begin
      r.region = REGION_MIX1;
      pos = b * 64'(K_R1_B);
      neg = i * 64'(K_R1_I);
    end else if (5 * i <= 4 * b) begin
      r.region = REGION_MIX2;
      pos = b * 64'(K_R2_B);
      neg = i * 64'(K_R2_I);
    end else begin
      r.region = REGION_MIX3;
      pos = b * 64'(K_R3_B);
      neg = i * 64'(K_R3_I);
    end
    if (pos <= neg) begin
      lx = 0;
    end else begin
      lx = ((pos - neg) + (64'd1 << (ROUND_SH - 1))) >> ROUND_SH;
      if (lx > 64'(LUX_MAX)) lx = 64'(LUX_MAX);
    end
    r.lux = LUX_W'(lx);
    return r;
  endfunction

  function automatic void add_reading(int bb, int ir, bit drain);
    reading_t rd;
    rd.bb = CNT_W'(bb);
    rd.ir = CNT_W'(ir);
    rd.drain_first = drain;
    pending_readings.push_back(rd);
  endfunction

  // Idle percentages per phase: sender 35/receiver 61, swapped, then none
  function automatic int send_idle_pct();
    if (readings_sent < 260) return 35;
    if (readings_sent < 520) return 61;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (readings_sent < 260) return 61;
    if (readings_sent < 520) return 35;
    return 0;
  endfunction

  // Stimulus
  initial begin
    int bb;
    int pct;
    fill_pow14();
    // corners and region boundaries
    add_reading(0, 0, 0);
    add_reading(0, 65535, 0);
    add_reading(65535, 0, 0);
    add_reading(65535, 65535, 0);
    add_reading(1, 0, 0);
    add_reading(1, 1, 0);
    add_reading(2, 1, 0);
    add_reading(65535, 1, 0);
    add_reading(65535, 32767, 0);
    add_reading(100, 50, 0);
    add_reading(100, 51, 0);
    add_reading(100, 61, 0);
    add_reading(100, 62, 0);
    add_reading(100, 80, 0);
    add_reading(100, 81, 0);
    add_reading(10, 13, 0);
    add_reading(10, 14, 0);
    add_reading(65535, 52428, 0);
    add_reading(65535, 65535 / 2 + 1, 0);
    add_reading(65535, 39976, 0);
    add_reading(50000, 64999, 0);
    add_reading(3, 2, 0);
    for (int n = 0; n < 730; n++) begin
      case ($urandom_range(0, 3))
        0: add_reading($urandom_range(0, 65535), $urandom_range(0, 65535), n == 300);
        1: begin
          bb  = $urandom_range(1, 65535);
          pct = $urandom_range(0, 140);
          add_reading(bb, (bb * pct) / 100, n == 300);
        end
        2: begin
          bb  = $urandom_range(1, 40);
          add_reading(bb, $urandom_range(0, 60), n == 300);
        end
        default: begin
          bb  = $urandom_range(1, 65535);
          pct = $urandom_range(0, 50);
          add_reading(bb, (bb * pct) / 100, n == 300);
        end
      endcase
    end
    pending_readings[22].drain_first = 1'b1;
    stim_ready = 1'b1;
  end

  // Driver
  always @(posedge clk) begin
    logic     nxt_valid;
    reading_t rd;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      nxt_valid = in_tvalid;
      if (in_tvalid && in_tready) begin
        expected_lux.push_back(compute_lux(in_tdata[15:0], in_tdata[31:16]));
        readings_sent++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && stim_ready && pending_readings.size() > 0 &&
          $urandom_range(0, 99) >= send_idle_pct()) begin
        rd = pending_readings[0];
        if (!(rd.drain_first && (expected_lux.size() > 0 || in_tvalid))) begin
          void'(pending_readings.pop_front());
          in_tdata  <= {rd.ir, rd.bb};
          nxt_valid = 1'b1;
        end
      end
      in_tvalid <= nxt_valid;
    end
  end

  // Monitor and checker
  always @(posedge clk) begin
    lux_result_t exp_r;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_lux.size() == 0) begin
          $error("unexpected result transaction: lux_scaled %0d", out_tdata[20:0]);
          errors++;
        end else begin
          exp_r = expected_lux.pop_front();
          if (out_tdata[20:0] !== exp_r.lux) begin
            $error("lux_scaled: expected %0d, got %0d", exp_r.lux, out_tdata[20:0]);
            errors++;
          end
          if (out_tuser !== exp_r.region) begin
            $error("ratio_region: expected %0d, got %0d", exp_r.region, out_tuser);
            errors++;
          end
        end
      end
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct());
    end
  end

  // End of run
  initial begin
    wait (stim_ready);
    @(posedge clk);
    while (pending_readings.size() > 0 || in_tvalid || expected_lux.size() > 0) begin
      @(posedge clk);
    end
    repeat (40) @(posedge clk);
    if (errors == 0 && expected_lux.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
